// ===== rtl/dtq_pkg.sv =====
// Shared types, widths and codes for the deadline timer queue.
`timescale 1ns / 1ps

package dtq_pkg;

    localparam int TIME_W          = 48;
    localparam int HANDLE_W        = 16;
    localparam int TAG_W           = 32;
    localparam int TABLE_DEPTH_DEF = 16;

    typedef enum logic [1:0] {
        REQ_ADD    = 2'd0,
        REQ_CANCEL = 2'd1,
        REQ_POLL   = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        EV_ADDED     = 3'd0,
        EV_REJECTED  = 3'd1,
        EV_CANCELLED = 3'd2,
        EV_NOT_FOUND = 3'd3,
        EV_EXPIRED   = 3'd4,
        EV_SUMMARY   = 3'd5
    } t_event;

    typedef enum logic [1:0] {
        QS_EMPTY = 2'd0,
        QS_NONE  = 2'd1,
        QS_SOME  = 2'd2
    } t_qstat;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic   load;
        logic   inc_idx;
        logic   insert;
        logic   remove;
        logic   emit;
        t_event ev;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic full;
        logic at_end;
        logic dl_gt;
        logic hd_eq;
        logic head_expired;
        logic out_free;
    } t_dp_sts;

endpackage

// ===== rtl/dtq_req_if.sv =====
// Request channel: valid/ready handshake with the request payload.
`timescale 1ns / 1ps

interface dtq_req_if import dtq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          req_type;
    logic [TIME_W-1:0]   time_value;
    logic [HANDLE_W-1:0] alarm_handle;
    logic [TAG_W-1:0]    resume_tag;

    modport source (output valid, req_type, time_value, alarm_handle, resume_tag,
                    input ready);
    modport sink   (input valid, req_type, time_value, alarm_handle, resume_tag,
                    output ready);
endinterface

// ===== rtl/dtq_res_if.sv =====
// Result channel: valid/ready handshake with the result payload.
`timescale 1ns / 1ps

interface dtq_res_if import dtq_pkg::*; ();
    logic                valid;
    logic                ready;
    t_event              event_res;
    logic [HANDLE_W-1:0] out_handle;
    logic [TAG_W-1:0]    out_tag;
    t_qstat              queue_status;
    logic                last;

    modport source (output valid, event_res, out_handle, out_tag, queue_status, last,
                    input ready);
    modport sink   (input valid, event_res, out_handle, out_tag, queue_status, last,
                    output ready);
endinterface

// ===== rtl/dtq_ctrl.sv =====
// Controller state machine: sequences scans, inserts, removals and results.
`timescale 1ns / 1ps

module dtq_ctrl import dtq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic [1:0] i_req_type,
    output logic       o_req_ready,
    input  t_dp_sts    i_sts,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_ADD,
        S_CANCEL,
        S_POLL
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;

    always_comb begin
        o_cmd   = '0;
        o_cmd.ev = EV_ADDED;
        n_state = r_state;
        n_ready = r_ready;
        unique case (r_state)
            S_IDLE: begin
                n_ready = 1'b1;
                if (i_req_valid && r_ready) begin
                    o_cmd.load = 1'b1;
                    case (i_req_type)
                        REQ_ADD: begin
                            n_state = S_ADD;
                            n_ready = 1'b0;
                        end
                        REQ_CANCEL: begin
                            n_state = S_CANCEL;
                            n_ready = 1'b0;
                        end
                        REQ_POLL: begin
                            n_state = S_POLL;
                            n_ready = 1'b0;
                        end
                        default: ; // unused code: drop silently
                    endcase
                end
            end
            S_ADD: begin
                if (i_sts.full) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.ev   = EV_REJECTED;
                        n_state    = S_IDLE;
                        n_ready    = 1'b1;
                    end
                end else if (i_sts.at_end || i_sts.dl_gt) begin
                    if (i_sts.out_free) begin
                        o_cmd.insert = 1'b1;
                        o_cmd.emit   = 1'b1;
                        o_cmd.ev     = EV_ADDED;
                        n_state      = S_IDLE;
                        n_ready      = 1'b1;
                    end
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            S_CANCEL: begin
                if (i_sts.at_end) begin
                    if (i_sts.out_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.ev   = EV_NOT_FOUND;
                        n_state    = S_IDLE;
                        n_ready    = 1'b1;
                    end
                end else if (i_sts.hd_eq) begin
                    if (i_sts.out_free) begin
                        o_cmd.remove = 1'b1;
                        o_cmd.emit   = 1'b1;
                        o_cmd.ev     = EV_CANCELLED;
                        n_state      = S_IDLE;
                        n_ready      = 1'b1;
                    end
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            S_POLL: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_sts.head_expired) begin
                        // pop the head, one per transfer
                        o_cmd.remove = 1'b1;
                        o_cmd.ev     = EV_EXPIRED;
                    end else begin
                        o_cmd.ev = EV_SUMMARY;
                        n_state  = S_IDLE;
                        n_ready  = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_req_ready = r_ready;

endmodule

// ===== rtl/dtq_datapath.sv =====
// Datapath: sorted entry table, scan index, request registers and result register.
`timescale 1ns / 1ps

module dtq_datapath import dtq_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [TIME_W-1:0]   i_time_value,
    input  logic [HANDLE_W-1:0] i_alarm_handle,
    input  logic [TAG_W-1:0]    i_resume_tag,
    input  t_dp_cmd             i_cmd,
    output t_dp_sts             o_sts,
    dtq_res_if.source           o_res
);

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = $clog2(TABLE_DEPTH);

    logic [TIME_W-1:0]   r_dl [TABLE_DEPTH];
    logic [HANDLE_W-1:0] r_hd [TABLE_DEPTH];
    logic [TAG_W-1:0]    r_tg [TABLE_DEPTH];

    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_idx;
    logic                r_any;
    logic [TIME_W-1:0]   r_req_time;
    logic [HANDLE_W-1:0] r_req_handle;
    logic [TAG_W-1:0]    r_req_tag;

    logic                r_out_valid;
    t_event              r_out_ev;
    logic [HANDLE_W-1:0] r_out_handle;
    logic [TAG_W-1:0]    r_out_tag;
    t_qstat              r_out_status;
    logic                r_out_last;

    logic [TIME_W-1:0]   w_sel_dl;
    logic [HANDLE_W-1:0] w_sel_hd;
    logic [TAG_W-1:0]    w_sel_tg;

    // Entry under the scan index; only looked at while the index is below the count
    assign w_sel_dl = r_dl[r_idx[IW-1:0]];
    assign w_sel_hd = r_hd[r_idx[IW-1:0]];
    assign w_sel_tg = r_tg[r_idx[IW-1:0]];

    assign o_sts.full         = (r_count == CW'(TABLE_DEPTH));
    assign o_sts.at_end       = (r_idx == r_count);
    assign o_sts.dl_gt        = (w_sel_dl > r_req_time);
    assign o_sts.hd_eq        = (w_sel_hd == r_req_handle);
    assign o_sts.head_expired = (r_count != '0) && (r_dl[0] < r_req_time);
    assign o_sts.out_free     = !r_out_valid || o_res.ready;

    // Each entry takes its neighbour below on insert, above on remove
    for (genvar j = 0; j < TABLE_DEPTH; j++) begin : g_entry
        localparam int PREV = (j > 0) ? j - 1 : 0;
        localparam int NEXT = (j < TABLE_DEPTH - 1) ? j + 1 : j;
        always_ff @(posedge i_clk) begin
            if (i_cmd.insert && (r_idx == CW'(j))) begin
                r_dl[j] <= r_req_time;
                r_hd[j] <= r_req_handle;
                r_tg[j] <= r_req_tag;
            end else if (i_cmd.insert && (r_idx < CW'(j))) begin
                r_dl[j] <= r_dl[PREV];
                r_hd[j] <= r_hd[PREV];
                r_tg[j] <= r_tg[PREV];
            end else if (i_cmd.remove && (r_idx <= CW'(j))) begin
                r_dl[j] <= r_dl[NEXT];
                r_hd[j] <= r_hd[NEXT];
                r_tg[j] <= r_tg[NEXT];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.insert) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.remove) begin
            r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx        <= '0;
            r_any        <= 1'b0;
            r_req_time   <= i_time_value;
            r_req_handle <= i_alarm_handle;
            r_req_tag    <= i_resume_tag;
        end else begin
            if (i_cmd.inc_idx) begin
                r_idx <= r_idx + CW'(1);
            end
            if (i_cmd.emit && (i_cmd.ev == EV_EXPIRED)) begin
                r_any <= 1'b1;
            end
        end
    end

    // Result register: hold until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_ev     <= i_cmd.ev;
            r_out_last   <= (i_cmd.ev != EV_EXPIRED);
            case (i_cmd.ev)
                EV_EXPIRED: r_out_handle <= w_sel_hd;
                EV_SUMMARY: r_out_handle <= '0;
                default:    r_out_handle <= r_req_handle;
            endcase
            case (i_cmd.ev) inside
                EV_CANCELLED, EV_EXPIRED: r_out_tag <= w_sel_tg;
                default:                  r_out_tag <= '0;
            endcase
            if ((i_cmd.ev != EV_SUMMARY) || (r_count == '0)) begin
                r_out_status <= QS_EMPTY;
            end else if (r_any) begin
                r_out_status <= QS_SOME;
            end else begin
                r_out_status <= QS_NONE;
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.event_res    = r_out_ev;
    assign o_res.out_handle   = r_out_handle;
    assign o_res.out_tag      = r_out_tag;
    assign o_res.queue_status = r_out_status;
    assign o_res.last         = r_out_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_insert_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |-> (r_count != CW'(TABLE_DEPTH)) && (r_idx <= r_count))
        else $error("insert into a full table or past the end");

    a_remove_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.remove |-> (r_idx < r_count))
        else $error("remove beyond the filled entries");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || o_res.ready))
        else $error("result overwritten before its transfer");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.insert |=> (r_count == $past(r_count) + CW'(1)))
        else $error("count did not advance after insert");

endmodule

// ===== rtl/deadline_timer_queue.sv =====
// Add and cancel run the one-entry-per-cycle scan of the sorted table, then write the
// result once the output register is free.
// Poll emits one result per expired entry, one result per cycle when taken, then a summary.
// Throughput: one request at a time; the next is taken the cycle after the last result
// is written, while that result still waits in the output register.
// Reset (synchronous, active low) empties the table; entry contents are not cleared.
`timescale 1ns / 1ps

module deadline_timer_queue import dtq_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dtq_req_if.sink   i_req,
    dtq_res_if.source o_res
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_ready;

    dtq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .o_req_ready (w_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    dtq_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_time_value   (i_req.time_value),
        .i_alarm_handle (i_req.alarm_handle),
        .i_resume_tag   (i_req.resume_tag),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .o_res          (o_res)
    );

    assign i_req.ready = w_ready;

endmodule
